// File: sv/g2e_pkg.sv
// Shared types, constants and elaboration-time constant functions of the geodetic to ECEF converter.
package g2e_pkg;

    localparam int CORD_W      = 62;
    localparam int MAG_W       = 62;
    localparam int HU_W        = 29;
    localparam int RSQRT_ITERS = 7;
    localparam int NEWTON_LAT  = 7;

    // Back-end timing, counted in pipeline advances after the quadrant map register.
    localparam int T_W       = 5;
    localparam int T_Y       = T_W + NEWTON_LAT * RSQRT_ITERS;
    localparam int T_NZ      = T_Y + 4;
    localparam int TAP_HU    = T_NZ - 1;
    localparam int TAP_LAT   = T_NZ + 1;
    localparam int TAP_LON   = T_NZ + 3;
    localparam int SIDE_LEN  = TAP_LON + 1;
    localparam int BACK_LAT  = T_NZ + 8;
    localparam int FRONT_LAT = 4;

    localparam logic [63:0] Q60       = 64'h1000_0000_0000_0000;
    localparam logic [63:0] THREE_Q60 = 64'h3000_0000_0000_0000;
    localparam logic [63:0] PI_NUM    = 64'd314159265359;
    localparam logic [63:0] PI_DEN    = 64'd100000000000;
    localparam logic [63:0] INVF_NUM  = 64'd298257223563;
    localparam logic [63:0] INVF_DEN  = 64'd1000000000;
    localparam logic [63:0] A_MM      = 64'd6378137000;
    localparam logic [63:0] OUT_LIMIT = 64'd7000000000;
    localparam logic [32:0] UNIT_QUARTER = 33'd754974720;
    localparam logic [32:0] UNIT_TURN    = 33'd3019898880;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [CORD_W-1:0] z;
    } cord_t;

    // floor(num * 2^sh / den) for num < den
    function automatic logic [63:0] frac_bits(input logic [63:0] num, input logic [63:0] den,
                                              input int sh);
        logic [64:0] r;
        logic [63:0] q;
        int k;
        r = {1'b0, num};
        q = '0;
        for (k = 0; k < sh; k++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= {1'b0, den})
            begin
                r = r - {1'b0, den};
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    // Long division, elaboration only.
    function automatic logic [63:0] div_u(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] r;
        logic [63:0] q;
        int k;
        r = '0;
        q = '0;
        for (k = 63; k >= 0; k--)
        begin
            r = {r[63:0], num[k]};
            if (r >= {1'b0, den})
            begin
                r = r - {1'b0, den};
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        p = p >> s;
        return p[63:0];
    endfunction

    function automatic logic [63:0] rsqrt_q60(input logic [63:0] w);
        logic [63:0] y;
        logic [63:0] t;
        int k;
        y = Q60;
        for (k = 0; k < RSQRT_ITERS; k++)
        begin
            t = mul_shr(w, mul_shr(y, y, 60), 60);
            t = (t < THREE_Q60) ? THREE_Q60 - t : 64'd0;
            y = mul_shr(y, t, 61);
        end
        return y;
    endfunction

    // atan(2^-i) in Q60, alternating series with truncated terms
    function automatic logic signed [63:0] atan_q60(input int i);
        logic signed [63:0] acc;
        logic [63:0] term;
        int k;
        int e;
        acc = '0;
        if (i == 0)
            acc = $signed(frac_bits(PI_NUM, 4 * PI_DEN, 60));
        else
        begin
            for (k = 0; k < 32; k++)
            begin
                e = i * (2 * k + 1);
                if (e <= 60)
                begin
                    term = div_u(Q60 >> e, 64'(2 * k + 1));
                    if ((k & 1) != 0)
                        acc = acc - $signed(term);
                    else
                        acc = acc + $signed(term);
                end
            end
        end
        return acc;
    endfunction

    // Inverse CORDIC gain in Q60
    function automatic logic [63:0] kc_q60(input int steps);
        logic [63:0] p;
        int i;
        p = Q60;
        for (i = 0; i < steps; i++)
            p = p + (p >> (2 * i));
        return rsqrt_q60(p >> 2) >> 1;
    endfunction

    localparam logic [31:0] KCONV    = 32'(frac_bits(PI_NUM, 180 * PI_DEN, 37));
    localparam logic [63:0] F_Q60    = frac_bits(INVF_DEN, INVF_NUM, 60);
    localparam logic [63:0] E2_Q60   = 2 * F_Q60 - mul_shr(F_Q60, F_Q60, 60);
    localparam logic [63:0] ONE_M_E2 = Q60 - E2_Q60;

endpackage

// File: sv/geodetic_to_ecef_top.sv
// Top level of the pipelined WGS84 geodetic to Earth-centred (ECEF) converter.
// Converts one geodetic position per clock into X, Y, Z in millimetres: two rows of
// CORDIC_STEPS cells produce sine and cosine of latitude and longitude side by side, then seven
// Newton cells form 1/sqrt for the prime-vertical radius, and every 64-bit product runs through
// a two-stage multiplier built from 32x32 partial products. A new position is taken every
// cycle as long as the output register or its skid stage has room; a stall at the output
// holds the whole pipeline. Angles outside +-180 degrees wrap, outputs saturate at
// +-7000000000 mm.
module geodetic_to_ecef_top #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // latitude[30:0], longitude[62:31], height_mm[90:63], undulation_mm[109:91], zero pad
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // x_mm[33:0], y_mm[67:34], z_mm[101:68], zero pad
    output logic [103:0] m_axis_tdata
);

    localparam int LAT    = CORDIC_STEPS + g2e_pkg::FRONT_LAT + g2e_pkg::BACK_LAT;
    localparam int MAG_W  = g2e_pkg::MAG_W;
    localparam int CORD_W = g2e_pkg::CORD_W;
    localparam int HU_W   = g2e_pkg::HU_W;
    localparam logic signed [CORD_W-1:0] X_START =
        CORD_W'(g2e_pkg::kc_q60(CORDIC_STEPS));

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    typedef struct packed {
        logic [MAG_W-1:0] c_mag;
        logic             c_neg;
        logic [MAG_W-1:0] s_mag;
        logic             s_neg;
    } trig_t;

    typedef struct packed {
        logic signed [HU_W-1:0] hu;
        trig_t                  lat;
        trig_t                  lon;
    } side_t;

    // Fold the rotated vector back into the angle's quadrant as magnitude and sign.
    function automatic trig_t map_quad(input g2e_pkg::cord_t v, input quad_t q);
        logic [MAG_W-1:0] mx, my;
        logic xn, xp, yn, yp;
        trig_t t;
        mx = v.x[CORD_W-1] ? MAG_W'(-v.x) : MAG_W'(v.x);
        my = v.y[CORD_W-1] ? MAG_W'(-v.y) : MAG_W'(v.y);
        xn = v.x[CORD_W-1];
        yn = v.y[CORD_W-1];
        xp = !xn && (v.x != '0);
        yp = !yn && (v.y != '0);
        unique case (q)
            QUAD_0:   t = '{c_mag: mx, c_neg: xn, s_mag: my, s_neg: yn};
            QUAD_90:  t = '{c_mag: my, c_neg: yp, s_mag: mx, s_neg: xn};
            QUAD_180: t = '{c_mag: mx, c_neg: xp, s_mag: my, s_neg: yp};
            QUAD_270: t = '{c_mag: my, c_neg: yn, s_mag: mx, s_neg: xp};
            default:  t = '{c_mag: mx, c_neg: xn, s_mag: my, s_neg: yn};
        endcase
        return t;
    endfunction

    // Q16 mm magnitude to mm, rounding half up, clipped at the output bound.
    function automatic logic [32:0] round_sat(input logic [63:0] p);
        logic [63:0] s;
        s = (p + 64'd32768) >> 16;
        return (s > g2e_pkg::OUT_LIMIT) ? 33'(g2e_pkg::OUT_LIMIT) : s[32:0];
    endfunction

    // ---------------- handshake and valid tracking ----------------
    logic           en;
    logic [LAT-1:0] valid_reg;
    logic           out_valid_reg, skid_valid_reg;
    logic [103:0]   out_data_reg, skid_data_reg, pipe_data;
    logic           pv;

    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;
    assign pv            = valid_reg[LAT-1];
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (en)
                valid_reg <= {valid_reg[LAT-2:0], s_axis_tvalid};
            if (skid_valid_reg)
            begin
                // drain the skid stage into the output register
                if (m_axis_tready)
                    skid_valid_reg <= 1'b0;
            end
            else if (pv)
            begin
                if (out_valid_reg && !m_axis_tready)
                    skid_valid_reg <= 1'b1;
                else
                    out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
                out_data_reg <= skid_data_reg;
        end
        else if (pv)
        begin
            if (out_valid_reg && !m_axis_tready)
                skid_data_reg <= pipe_data;
            else
                out_data_reg <= pipe_data;
        end
    end

    // ---------------- front end: angle reduction ----------------
    logic signed [30:0] latitude;
    logic signed [31:0] longitude;
    logic signed [27:0] height_mm;
    logic signed [18:0] undulation_mm;

    assign latitude      = s_axis_tdata[30:0];
    assign longitude     = s_axis_tdata[62:31];
    assign height_mm     = s_axis_tdata[90:63];
    assign undulation_mm = s_axis_tdata[109:91];

    logic [32:0]            ang [2];
    logic [31:0]            r_reg [2];
    logic [29:0]            rem_reg [2];
    quad_t                  q_reg [2];
    quad_t                  q_c_reg [2];
    logic [CORD_W-1:0]      z0_reg [2];
    logic signed [HU_W-1:0] hu_a_reg, hu_b_reg, hu_c_reg;
    logic [32:0]            d1 [2], d2 [2], d3 [2];

    assign ang[0] = {{2{latitude[30]}}, latitude};
    assign ang[1] = {longitude[31], longitude};

    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            d1[k] = {1'b0, r_reg[k]} - g2e_pkg::UNIT_QUARTER;
            d2[k] = {1'b0, r_reg[k]} - 33'(2 * g2e_pkg::UNIT_QUARTER);
            d3[k] = {1'b0, r_reg[k]} - 33'(3 * g2e_pkg::UNIT_QUARTER);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 2; k++)
            begin
                // wrap negative angles by one turn
                r_reg[k] <= ang[k][32] ? 32'(ang[k] + g2e_pkg::UNIT_TURN) : ang[k][31:0];
                priority if (!d3[k][32])
                begin
                    q_reg[k]   <= QUAD_270;
                    rem_reg[k] <= d3[k][29:0];
                end
                else if (!d2[k][32])
                begin
                    q_reg[k]   <= QUAD_180;
                    rem_reg[k] <= d2[k][29:0];
                end
                else if (!d1[k][32])
                begin
                    q_reg[k]   <= QUAD_90;
                    rem_reg[k] <= d1[k][29:0];
                end
                else
                begin
                    q_reg[k]   <= QUAD_0;
                    rem_reg[k] <= r_reg[k][29:0];
                end
                z0_reg[k]  <= CORD_W'(rem_reg[k]) * CORD_W'(g2e_pkg::KCONV);
                q_c_reg[k] <= q_reg[k];
            end
            hu_a_reg <= HU_W'(height_mm) + HU_W'(undulation_mm);
            hu_b_reg <= hu_a_reg;
            hu_c_reg <= hu_b_reg;
        end
    end

    // ---------------- CORDIC rows ----------------
    g2e_pkg::cord_t    lat_v [CORDIC_STEPS+1];
    g2e_pkg::cord_t    lon_v [CORDIC_STEPS+1];
    logic [HU_W+1:0]   lat_tag [CORDIC_STEPS+1];
    logic [1:0]        lon_tag [CORDIC_STEPS+1];

    assign lat_v[0]   = '{x: X_START, y: '0, z: $signed(z0_reg[0])};
    assign lon_v[0]   = '{x: X_START, y: '0, z: $signed(z0_reg[1])};
    assign lat_tag[0] = {hu_c_reg, q_c_reg[0]};
    assign lon_tag[0] = q_c_reg[1];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cells
        g2e_cordic_cell #(.STAGE(i), .TAG_W(HU_W + 2)) u_lat_cell (
            .clk(clk), .en(en),
            .v_in(lat_v[i]), .tag_in(lat_tag[i]),
            .v_out(lat_v[i+1]), .tag_out(lat_tag[i+1])
        );
        g2e_cordic_cell #(.STAGE(i), .TAG_W(2)) u_lon_cell (
            .clk(clk), .en(en),
            .v_in(lon_v[i]), .tag_in(lon_tag[i]),
            .v_out(lon_v[i+1]), .tag_out(lon_tag[i+1])
        );
    end

    // ---------------- quadrant map and side delay line ----------------
    side_t map_reg;
    side_t side_reg [g2e_pkg::SIDE_LEN];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            map_reg.hu  <= lat_tag[CORDIC_STEPS][HU_W+1:2];
            map_reg.lat <= map_quad(lat_v[CORDIC_STEPS], quad_t'(lat_tag[CORDIC_STEPS][1:0]));
            map_reg.lon <= map_quad(lon_v[CORDIC_STEPS], quad_t'(lon_tag[CORDIC_STEPS]));
            side_reg[0] <= map_reg;
            for (int k = 1; k < g2e_pkg::SIDE_LEN; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // ---------------- prime-vertical radius ----------------
    logic [63:0] sl_q;
    logic [63:0] t1, t2;
    logic [63:0] w_reg;
    logic [63:0] y_w [g2e_pkg::RSQRT_ITERS+1];
    logic [63:0] w_w [g2e_pkg::RSQRT_ITERS+1];
    logic [63:0] nq, nz;
    logic [63:0] nq_d1_reg, nq_d2_reg;

    assign sl_q = 64'(map_reg.lat.s_mag);

    g2e_mulq #(.SHIFT(60)) u_sin2 (.clk(clk), .en(en), .a(sl_q), .b(sl_q), .p(t1));
    g2e_mulq #(.SHIFT(60)) u_e2 (
        .clk(clk), .en(en), .a(g2e_pkg::E2_Q60), .b(t1), .p(t2)
    );

    always_ff @(posedge clk)
    begin
        if (en)
            w_reg <= g2e_pkg::Q60 - t2;
    end

    assign y_w[0] = g2e_pkg::Q60;
    assign w_w[0] = w_reg;

    for (genvar k = 0; k < g2e_pkg::RSQRT_ITERS; k++)
    begin : g_newton
        g2e_newton_cell u_newton (
            .clk(clk), .en(en),
            .y_in(y_w[k]), .w_in(w_w[k]),
            .y_out(y_w[k+1]), .w_out(w_w[k+1])
        );
    end

    g2e_mulq #(.SHIFT(44)) u_nq (
        .clk(clk), .en(en), .a(g2e_pkg::A_MM), .b(y_w[g2e_pkg::RSQRT_ITERS]), .p(nq)
    );
    g2e_mulq #(.SHIFT(60)) u_nz (
        .clk(clk), .en(en), .a(nq), .b(g2e_pkg::ONE_M_E2), .p(nz)
    );

    // ---------------- radii and final products ----------------
    side_t             s_hu, s_lat, s_lon;
    logic signed [63:0] hu_q;
    logic signed [63:0] rh_reg, rz_reg;
    logic [63:0]        rh_mag_reg, rz_mag_reg;
    logic               rh_neg_reg, rz_neg_reg;
    logic               xs_a_reg, xs_b_reg;
    logic [3:0]         zs_reg;
    logic [1:0]         xn_reg, yn_reg;
    logic [63:0]        rc, zp, xp, yp;
    logic [63:0]        zp_d1_reg, zp_d2_reg;
    logic [32:0]        xm_reg, ym_reg, zm_reg;
    logic               xf_neg_reg, yf_neg_reg, zf_neg_reg;
    logic [33:0]        x_fin_reg, y_fin_reg, z_fin_reg;

    assign s_hu  = side_reg[g2e_pkg::TAP_HU];
    assign s_lat = side_reg[g2e_pkg::TAP_LAT];
    assign s_lon = side_reg[g2e_pkg::TAP_LON];
    assign hu_q  = {{(64 - HU_W - 16){s_hu.hu[HU_W-1]}}, s_hu.hu, 16'b0};

    g2e_mulq #(.SHIFT(60)) u_rc (
        .clk(clk), .en(en), .a(rh_mag_reg), .b(64'(s_lat.lat.c_mag)), .p(rc)
    );
    g2e_mulq #(.SHIFT(60)) u_zp (
        .clk(clk), .en(en), .a(rz_mag_reg), .b(64'(s_lat.lat.s_mag)), .p(zp)
    );
    g2e_mulq #(.SHIFT(60)) u_xp (
        .clk(clk), .en(en), .a(rc), .b(64'(s_lon.lon.c_mag)), .p(xp)
    );
    g2e_mulq #(.SHIFT(60)) u_yp (
        .clk(clk), .en(en), .a(rc), .b(64'(s_lon.lon.s_mag)), .p(yp)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nq_d1_reg <= nq;
            nq_d2_reg <= nq_d1_reg;
            rh_reg    <= $signed(nq_d2_reg) + hu_q;
            rz_reg    <= $signed(nz) + hu_q;

            rh_mag_reg <= rh_reg[63] ? 64'(-rh_reg) : 64'(rh_reg);
            rh_neg_reg <= rh_reg[63];
            rz_mag_reg <= rz_reg[63] ? 64'(-rz_reg) : 64'(rz_reg);
            rz_neg_reg <= rz_reg[63];

            // carry product signs alongside the multipliers
            xs_a_reg  <= rh_neg_reg ^ s_lat.lat.c_neg;
            xs_b_reg  <= xs_a_reg;
            zs_reg    <= {zs_reg[2:0], rz_neg_reg ^ s_lat.lat.s_neg};
            xn_reg    <= {xn_reg[0], xs_b_reg ^ s_lon.lon.c_neg};
            yn_reg    <= {yn_reg[0], xs_b_reg ^ s_lon.lon.s_neg};
            zp_d1_reg <= zp;
            zp_d2_reg <= zp_d1_reg;

            xm_reg     <= round_sat(xp);
            ym_reg     <= round_sat(yp);
            zm_reg     <= round_sat(zp_d2_reg);
            xf_neg_reg <= xn_reg[1];
            yf_neg_reg <= yn_reg[1];
            zf_neg_reg <= zs_reg[3];

            x_fin_reg <= xf_neg_reg ? -{1'b0, xm_reg} : {1'b0, xm_reg};
            y_fin_reg <= yf_neg_reg ? -{1'b0, ym_reg} : {1'b0, ym_reg};
            z_fin_reg <= zf_neg_reg ? -{1'b0, zm_reg} : {1'b0, zm_reg};
        end
    end

    assign pipe_data = {2'b0, z_fin_reg, y_fin_reg, x_fin_reg};

endmodule

// File: sv/g2e_mulq.sv
// Two-stage pipelined 64x64 multiplier returning product bits [SHIFT+63:SHIFT].
module g2e_mulq #(
    parameter int SHIFT = 60
) (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic [63:0] p
);

    logic [63:0]  ll_reg, lh_reg, hl_reg, hh_reg;
    logic [64:0]  mid;
    logic [127:0] sum;
    logic [63:0]  p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= 64'(a[31:0]) * 64'(b[31:0]);
            lh_reg <= 64'(a[31:0]) * 64'(b[63:32]);
            hl_reg <= 64'(a[63:32]) * 64'(b[31:0]);
            hh_reg <= 64'(a[63:32]) * 64'(b[63:32]);
            p_reg  <= sum[SHIFT +: 64];
        end
    end

    assign mid = {1'b0, lh_reg} + {1'b0, hl_reg};
    assign sum = {hh_reg, ll_reg} + {31'b0, mid, 32'b0};
    assign p   = p_reg;

endmodule

// File: sv/g2e_newton_cell.sv
// One Newton step y' = y(3 - w y^2)/2 of the reciprocal square root, seven stages deep.
module g2e_newton_cell (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] y_in,
    input  logic [63:0] w_in,
    output logic [63:0] y_out,
    output logic [63:0] w_out
);

    logic [63:0] y_dly_reg [5];
    logic [63:0] w_dly_reg [7];
    logic [63:0] sq;
    logic [63:0] wt;
    logic [63:0] tp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_dly_reg[0] <= y_in;
            for (int i = 1; i < 5; i++)
                y_dly_reg[i] <= y_dly_reg[i-1];
            w_dly_reg[0] <= w_in;
            for (int i = 1; i < 7; i++)
                w_dly_reg[i] <= w_dly_reg[i-1];
            tp_reg <= (wt < g2e_pkg::THREE_Q60) ? g2e_pkg::THREE_Q60 - wt : 64'd0;
        end
    end

    g2e_mulq #(.SHIFT(60)) u_sq (.clk(clk), .en(en), .a(y_in), .b(y_in), .p(sq));
    g2e_mulq #(.SHIFT(60)) u_wt (.clk(clk), .en(en), .a(w_dly_reg[1]), .b(sq), .p(wt));
    g2e_mulq #(.SHIFT(61)) u_y  (.clk(clk), .en(en), .a(y_dly_reg[4]), .b(tp_reg), .p(y_out));

    assign w_out = w_dly_reg[6];

endmodule

// File: sv/g2e_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation with a registered output and a carried tag.
module g2e_cordic_cell #(
    parameter int STAGE = 0,
    parameter int TAG_W = 2
) (
    input  logic                  clk,
    input  logic                  en,
    input  g2e_pkg::cord_t        v_in,
    input  logic [TAG_W-1:0]      tag_in,
    output g2e_pkg::cord_t        v_out,
    output logic [TAG_W-1:0]      tag_out
);

    localparam logic signed [g2e_pkg::CORD_W-1:0] ATAN =
        g2e_pkg::CORD_W'(g2e_pkg::atan_q60(STAGE));

    logic signed [g2e_pkg::CORD_W-1:0] dx, dy;
    g2e_pkg::cord_t v_next;
    g2e_pkg::cord_t v_reg;
    logic [TAG_W-1:0] tag_reg;

    always_comb
    begin
        dx = v_in.y >>> STAGE;
        dy = v_in.x >>> STAGE;
        if (!v_in.z[g2e_pkg::CORD_W-1])
        begin
            v_next.x = v_in.x - dx;
            v_next.y = v_in.y + dy;
            v_next.z = v_in.z - ATAN;
        end
        else
        begin
            v_next.x = v_in.x + dx;
            v_next.y = v_in.y - dy;
            v_next.z = v_in.z + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg   <= v_next;
            tag_reg <= tag_in;
        end
    end

    assign v_out   = v_reg;
    assign tag_out = tag_reg;

endmodule

// File: tb/geodetic_to_ecef_top_tb.sv
// Self-checking testbench for the pipelined WGS84 geodetic to ECEF converter.
`timescale 1ns / 1ps

module geodetic_to_ecef_top_tb;

    localparam int STEPS       = 24;
    localparam int LATENCY     = STEPS + 70;
    localparam longint QUARTER = 64'sd754974720;
    localparam longint TURN    = 64'sd3019898880;
    localparam longint XYZ_MAX = 64'sd7000000000;
    localparam bit [63:0] ONE  = 64'h1000_0000_0000_0000;

    // Idle modes of the stimulus phases
    typedef enum int {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [33:0] x;
        logic [33:0] y;
        logic [33:0] z;
    } ecef_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [103:0] m_axis_tdata;

    logic [111:0] pending_pos[$];
    ecef_t        ecef_due[$];
    idle_mode_t   idle_mode;
    int           errors;
    int           hold_left;
    logic         hold_req;

    // Constants of the converter, computed once at time zero
    longint    atan_rom[STEPS];
    bit [63:0] inv_gain;
    bit [63:0] deg_to_rad;
    bit [63:0] ecc_sq;

    geodetic_to_ecef_top #(.CORDIC_STEPS(STEPS)) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------- arithmetic

    // floor(num * 2^sh / den), num < den
    function automatic bit [63:0] div_frac(bit [63:0] num, bit [63:0] den, int sh);
        bit [64:0] rem;
        bit [63:0] quo;
        rem = {1'b0, num};
        quo = '0;
        for (int k = 0; k < sh; k++)
        begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= {1'b0, den})
            begin
                rem = rem - {1'b0, den};
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic bit [63:0] umul_shift(bit [63:0] a, bit [63:0] b, int s);
        bit [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        p = p >> s;
        return p[63:0];
    endfunction

    // Seven Newton steps of 1/sqrt(w) from one, all Q60
    function automatic bit [63:0] inv_sqrt(bit [63:0] w);
        bit [63:0] y;
        bit [63:0] t;
        y = ONE;
        for (int k = 0; k < 7; k++)
        begin
            t = umul_shift(w, umul_shift(y, y, 60), 60);
            t = (t < 3 * ONE) ? 3 * ONE - t : 64'd0;
            y = umul_shift(y, t, 61);
        end
        return y;
    endfunction

    // Reduce the angle to a quadrant, rotate the remainder, then map the quadrant
    function automatic void rotate_angle(longint ang, output longint c, output longint s);
        longint r;
        longint quad;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        r = ang % TURN;
        if (r < 0)
            r += TURN;
        quad = r / QUARTER;
        r = r - quad * QUARTER;
        x = longint'(inv_gain);
        y = 0;
        z = r * longint'(deg_to_rad);
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= atan_rom[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                z += atan_rom[i];
            end
        end
        case (quad)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    // v * c / 2^60, truncated toward zero
    function automatic longint scale_by(longint v, longint c);
        bit [63:0] mag;
        mag = umul_shift((v < 0) ? -v : v, (c < 0) ? -c : c, 60);
        return ((v < 0) != (c < 0)) ? -longint'(mag) : longint'(mag);
    endfunction

    // Q16 mm to mm, round half away from zero, clip at the output range
    function automatic logic [33:0] to_mm(longint q16);
        longint r;
        r = (((q16 < 0) ? -q16 : q16) + 32768) >>> 16;
        if (q16 < 0)
            r = -r;
        if (r > XYZ_MAX)
            r = XYZ_MAX;
        if (r < -XYZ_MAX)
            r = -XYZ_MAX;
        return r[33:0];
    endfunction

    function automatic ecef_t geodetic_to_ecef(logic [111:0] pos);
        longint lat;
        longint lon;
        longint hu;
        longint cl;
        longint sl;
        longint cn;
        longint sn;
        longint rh;
        longint rz;
        longint rc;
        bit [63:0] sm;
        bit [63:0] w;
        bit [63:0] nq;
        bit [63:0] nz;
        ecef_t res;
        lat = longint'($signed(pos[30:0]));
        lon = longint'($signed(pos[62:31]));
        hu  = (longint'($signed(pos[90:63])) + longint'($signed(pos[109:91]))) * 65536;
        rotate_angle(lat, cl, sl);
        rotate_angle(lon, cn, sn);
        sm = (sl < 0) ? -sl : sl;
        w  = ONE - umul_shift(ecc_sq, umul_shift(sm, sm, 60), 60);
        nq = umul_shift(64'd6378137000, inv_sqrt(w), 44);
        nz = umul_shift(nq, ONE - ecc_sq, 60);
        rh = longint'(nq) + hu;
        rz = longint'(nz) + hu;
        rc = scale_by(rh, cl);
        res.x = to_mm(scale_by(rc, cn));
        res.y = to_mm(scale_by(rc, sn));
        res.z = to_mm(scale_by(rz, sl));
        return res;
    endfunction

    function automatic logic [111:0] pack_pos(longint lat, longint lon, longint h, longint u);
        return {2'b0, u[18:0], h[27:0], lon[31:0], lat[30:0]};
    endfunction

    // Half the draws inside the documented ranges, half anywhere in the field
    function automatic logic [111:0] random_pos();
        longint lat;
        longint lon;
        longint h;
        longint u;
        if ($urandom_range(1, 0))
        begin
            lat = longint'($urandom_range(1509949440, 0)) - QUARTER;
            lon = longint'($urandom_range(32'd3019898880, 0)) - 2 * QUARTER;
            h   = longint'($urandom_range(101000000, 0)) - 1000000;
            u   = longint'($urandom_range(400000, 0)) - 200000;
        end
        else
        begin
            lat = longint'($urandom());
            lon = longint'($urandom());
            h   = longint'($urandom());
            u   = longint'($urandom());
        end
        return pack_pos(lat, lon, h, u);
    endfunction

    task automatic report(string field, logic [33:0] got, logic [33:0] want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field,
                 $signed(got), $signed(want));
        errors++;
    endtask

    // ---------------------------------------------------------------- driver

    // Advance to the next pending position once the current transfer is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_pos.size() > 0 &&
                !((idle_mode == IDLE_TX && $urandom_range(99, 0) < 70) ||
                  (idle_mode == IDLE_BOTH && $urandom_range(99, 0) < 12)))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_pos.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Long output hold-off, counted here so the sender keeps going meanwhile
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (hold_req)
            hold_left <= 4 * LATENCY;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_req || hold_left > 1)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= !((idle_mode == IDLE_RX && $urandom_range(99, 0) < 70) ||
                               (idle_mode == IDLE_BOTH && $urandom_range(99, 0) < 12));
    end

    // ---------------------------------------------------------------- monitor

    // Predict on every input transfer, check on every output transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                ecef_due.push_back(geodetic_to_ecef(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (ecef_due.size() == 0)
                begin
                    $display("%0t: output transfer with no position outstanding", $realtime);
                    errors++;
                end
                else
                begin
                    ecef_t want;
                    want = ecef_due.pop_front();
                    if (m_axis_tdata[33:0] !== want.x)
                        report("x_mm", m_axis_tdata[33:0], want.x);
                    if (m_axis_tdata[67:34] !== want.y)
                        report("y_mm", m_axis_tdata[67:34], want.y);
                    if (m_axis_tdata[101:68] !== want.z)
                        report("z_mm", m_axis_tdata[101:68], want.z);
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic drain();
        while (pending_pos.size() > 0 || s_axis_tvalid || ecef_due.size() > 0)
            @(posedge clk);
    endtask

    task automatic random_burst(int count);
        for (int k = 0; k < count; k++)
            pending_pos.push_back(random_pos());
    endtask

    initial
    begin
        longint acc;
        bit [63:0] p;
        bit [63:0] flat;

        // Build the arctangent table, the gain and the ellipsoid constants
        atan_rom[0] = longint'(div_frac(64'd314159265359, 64'd400000000000, 60));
        for (int i = 1; i < STEPS; i++)
        begin
            acc = 0;
            for (int k = 0; i * (2 * k + 1) <= 60; k++)
            begin
                if (k % 2 != 0)
                    acc -= longint'((ONE >> (i * (2 * k + 1))) / (2 * k + 1));
                else
                    acc += longint'((ONE >> (i * (2 * k + 1))) / (2 * k + 1));
            end
            atan_rom[i] = acc;
        end
        p = ONE;
        for (int i = 0; i < STEPS; i++)
            p = p + (p >> (2 * i));
        inv_gain   = inv_sqrt(p >> 2) >> 1;
        deg_to_rad = div_frac(64'd314159265359, 64'd18000000000000, 37);
        flat       = div_frac(64'd1000000000, 64'd298257223563, 60);
        ecc_sq     = 2 * flat - umul_shift(flat, flat, 60);

        clk       = 1'b0;
        rst_n     = 1'b0;
        errors    = 0;
        hold_req  = 1'b0;
        idle_mode = IDLE_NONE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: poles, equator, date line, wrap, height and undulation extremes
        pending_pos.push_back(pack_pos(0, 0, 0, 0));
        pending_pos.push_back(pack_pos(QUARTER, 0, 0, 0));
        pending_pos.push_back(pack_pos(-QUARTER, 0, 0, 0));
        pending_pos.push_back(pack_pos(0, 2 * QUARTER, 0, 0));
        pending_pos.push_back(pack_pos(0, -2 * QUARTER, 0, 0));
        pending_pos.push_back(pack_pos(0, QUARTER, 0, 0));
        pending_pos.push_back(pack_pos(0, -QUARTER, 0, 0));
        pending_pos.push_back(pack_pos(QUARTER / 2, QUARTER / 2, 100000000, 200000));
        pending_pos.push_back(pack_pos(-QUARTER / 2, -QUARTER / 3, -1000000, -200000));
        pending_pos.push_back(pack_pos(QUARTER, 2 * QUARTER, 100000000, 200000));
        pending_pos.push_back(pack_pos(-QUARTER, -2 * QUARTER, -1000000, -200000));
        // latitude beyond the poles, longitude past the date line
        pending_pos.push_back(pack_pos(-(64'sd1 << 30), 0, 0, 0));
        pending_pos.push_back(pack_pos((64'sd1 << 30) - 1, 0, 0, 0));
        pending_pos.push_back(pack_pos(QUARTER + 1, 3 * QUARTER, 0, 0));
        pending_pos.push_back(pack_pos(0, -(64'sd1 << 31), 0, 0));
        pending_pos.push_back(pack_pos(0, (64'sd1 << 31) - 1, 0, 0));
        pending_pos.push_back(pack_pos(1, -1, 1, -1));
        // field extremes of height and undulation
        pending_pos.push_back(pack_pos(0, 0, (64'sd1 << 27) - 1, (64'sd1 << 18) - 1));
        pending_pos.push_back(pack_pos(0, 0, -(64'sd1 << 27), -(64'sd1 << 18)));
        pending_pos.push_back(pack_pos(QUARTER, 0, -(64'sd1 << 27), -(64'sd1 << 18)));
        pending_pos.push_back(pack_pos(-QUARTER, 2 * QUARTER, (64'sd1 << 27) - 1, 0));
        // Hold the sender until every directed result is back
        drain();

        // Random phases with each idle pattern
        idle_mode = IDLE_NONE;
        random_burst(250);
        drain();
        idle_mode = IDLE_TX;
        random_burst(200);
        drain();
        idle_mode = IDLE_RX;
        random_burst(200);
        drain();
        idle_mode = IDLE_BOTH;
        random_burst(200);
        drain();

        // Back-pressure: stall the output long enough to fill the pipeline
        idle_mode = IDLE_NONE;
        random_burst(200);
        @(posedge clk);
        hold_req <= 1'b1;
        while (hold_left == 0)
            @(posedge clk);
        hold_req <= 1'b0;
        drain();

        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("geodetic_to_ecef_top verification clean");
        else
            $display("geodetic_to_ecef_top verification failed");
        $finish;
    end

    // Drop out if the run hangs
    initial
    begin
        #20_000_000;
        $display("geodetic_to_ecef_top verification failed");
        $finish;
    end

endmodule

// File: sim.f
sv/g2e_pkg.sv
sv/g2e_mulq.sv
sv/g2e_newton_cell.sv
sv/g2e_cordic_cell.sv
sv/geodetic_to_ecef_top.sv
tb/geodetic_to_ecef_top_tb.sv
